### rtl/core/debug_trigger_address_match_macros.svh
// Assertion macros shared by the debug trigger RTL.
`ifndef DEBUG_TRIGGER_ADDRESS_MATCH_MACROS_SVH
`define DEBUG_TRIGGER_ADDRESS_MATCH_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define DTAM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the module's clk_i and rst_ni.
`define DTAM_ASSERT(lbl, prop, msg) `DTAM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/dtam_pkg.sv
// Types, codes and field positions of the debug trigger unit.
`default_nettype none

package dtam_pkg;

  localparam int unsigned NumSlotsDef = 4;
  localparam int unsigned XLEN        = 32;
  localparam int unsigned SlotIdxW    = 4;
  localparam int unsigned FieldW      = 4;

  // tdata1 (mcontrol) layout
  localparam int unsigned TypeLsb   = 28;
  localparam int unsigned ActionLsb = 12;
  localparam int unsigned ChainBit  = 11;
  localparam int unsigned MatchLsb  = 7;
  localparam int unsigned ModeUBit  = 3;
  localparam int unsigned ModeSBit  = 4;
  localparam int unsigned ModeMBit  = 6;
  localparam int unsigned DmodeBit  = 27;
  localparam logic [FieldW-1:0] TypeAddrMatch = 4'd2;

  // tcontrol
  localparam int unsigned MteBit = 3;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CHECK = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    REG_TSELECT  = 2'd0,
    REG_TDATA1   = 2'd1,
    REG_TDATA2   = 2'd2,
    REG_TCONTROL = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_STORE = 2'd1,
    KIND_EXEC  = 2'd2
  } access_kind_e;

  typedef enum logic [1:0] {
    PRIV_U = 2'd0,
    PRIV_S = 2'd1,
    PRIV_M = 2'd3
  } priv_e;

  typedef struct packed {
    logic                en;
    reg_sel_e            sel;
    logic [XLEN-1:0]     data;
  } wr_t;

  typedef struct packed {
    logic                fired;
    logic [SlotIdxW-1:0] slot;
  } hit_t;

endpackage

`default_nettype wire

### rtl/core/dtam_if.sv
// Request and response channel interfaces of the debug trigger unit.
`default_nettype none

interface dtam_req_if import dtam_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      opcode;
  logic [1:0]      reg_select;
  logic [XLEN-1:0] write_data;
  logic [XLEN-1:0] access_address;
  logic [1:0]      access_kind;
  logic [1:0]      privilege_level;

  modport source (
    output valid, opcode, reg_select, write_data, access_address, access_kind,
           privilege_level,
    input  ready
  );
  modport sink (
    input  valid, opcode, reg_select, write_data, access_address, access_kind,
           privilege_level,
    output ready
  );
endinterface

interface dtam_rsp_if import dtam_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [XLEN-1:0]     read_data;
  logic                trigger_fired;
  logic [SlotIdxW-1:0] fired_slot;
  logic [XLEN-1:0]     trap_value;

  modport source (
    output valid, read_data, trigger_fired, fired_slot, trap_value,
    input  ready
  );
  modport sink (
    input  valid, read_data, trigger_fired, fired_slot, trap_value,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/dtam_regs.sv
// Trigger CSR storage: tselect, per-slot tdata1/tdata2, tcontrol, and read mux.
`default_nettype none
`include "debug_trigger_address_match_macros.svh"

module dtam_regs import dtam_pkg::*; #(
  parameter int unsigned NumSlots = NumSlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wr_t             wr_i,
  input  reg_sel_e        rd_sel_i,
  output logic [XLEN-1:0] rd_data_o,
  output logic [XLEN-1:0] ctrl_o [NumSlots],
  output logic [XLEN-1:0] cmp_o  [NumSlots],
  output logic            mte_o
);

  localparam int unsigned SelW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam logic [SlotIdxW-1:0] LastSlot = SlotIdxW'(NumSlots - 1);

  logic [SlotIdxW-1:0] tsel_q, tsel_d;
  logic [XLEN-1:0]     ctrl_q [NumSlots];
  logic [XLEN-1:0]     cmp_q  [NumSlots];
  logic [XLEN-1:0]     tctrl_q;
  logic [SelW-1:0]     idx;
  logic [XLEN-1:0]     tdata1_wr;

  // tselect never leaves the implemented range, so it indexes directly
  assign idx = tsel_q[SelW-1:0];

  always_comb begin
    tsel_d = (wr_i.data >= XLEN'(NumSlots)) ? LastSlot : wr_i.data[SlotIdxW-1:0];
    tdata1_wr = wr_i.data;
    tdata1_wr[DmodeBit] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsel_q  <= '0;
      tctrl_q <= '0;
      for (int i = 0; i < int'(NumSlots); i++) begin
        ctrl_q[i] <= '0;
        cmp_q[i]  <= '0;
      end
    end else if (wr_i.en) begin
      case (wr_i.sel)
        REG_TSELECT:  tsel_q      <= tsel_d;
        REG_TDATA1:   ctrl_q[idx] <= tdata1_wr;
        REG_TDATA2:   cmp_q[idx]  <= wr_i.data;
        REG_TCONTROL: tctrl_q     <= wr_i.data;
        default:      tctrl_q     <= tctrl_q;
      endcase
    end
  end

  always_comb begin
    case (rd_sel_i)
      REG_TSELECT:  rd_data_o = XLEN'(tsel_q);
      REG_TDATA1:   rd_data_o = ctrl_q[idx];
      REG_TDATA2:   rd_data_o = cmp_q[idx];
      REG_TCONTROL: rd_data_o = tctrl_q;
      default:      rd_data_o = '0;
    endcase
  end

  assign ctrl_o = ctrl_q;
  assign cmp_o  = cmp_q;
  assign mte_o  = tctrl_q[MteBit];

  `DTAM_ASSERT(a_tsel_in_range, tsel_q < NumSlots, "tselect beyond last slot")
  `DTAM_ASSERT(a_dmode_never_set, rd_sel_i == REG_TDATA1 |-> !rd_data_o[DmodeBit], "dmode set")
  `DTAM_ASSERT(a_tsel_saturates, wr_i.en && wr_i.sel == REG_TSELECT && wr_i.data >= NumSlots |=> tsel_q == LastSlot, "tselect did not saturate")

endmodule

`default_nettype wire

### rtl/core/dtam_match.sv
// Parallel address-match compare over all slots with lowest-index priority.
`default_nettype none

module dtam_match import dtam_pkg::*; #(
  parameter int unsigned NumSlots = NumSlotsDef
) (
  input  logic [XLEN-1:0] ctrl_i [NumSlots],
  input  logic [XLEN-1:0] cmp_i  [NumSlots],
  input  logic            mte_i,
  input  logic [XLEN-1:0] addr_i,
  input  logic [1:0]      kind_i,
  input  logic [1:0]      priv_i,
  output hit_t            hit_o
);

  logic [NumSlots-1:0] fire;

  always_comb begin
    for (int i = 0; i < int'(NumSlots); i++) begin
      logic [XLEN-1:0] c;
      logic            kind_ok;
      logic            mode_ok;
      c = ctrl_i[i];
      case (kind_i)
        KIND_LOAD:  kind_ok = c[0];
        KIND_STORE: kind_ok = c[1];
        KIND_EXEC:  kind_ok = c[2];
        default:    kind_ok = 1'b0;
      endcase
      case (priv_i)
        PRIV_U:  mode_ok = c[ModeUBit];
        PRIV_S:  mode_ok = c[ModeSBit];
        PRIV_M:  mode_ok = c[ModeMBit] && mte_i;
        default: mode_ok = 1'b0;
      endcase
      fire[i] = (c[TypeLsb +: FieldW] == TypeAddrMatch) &&
                (c[ActionLsb +: FieldW] == '0) &&
                !c[ChainBit] &&
                (c[MatchLsb +: FieldW] == '0) &&
                kind_ok && mode_ok && (cmp_i[i] == addr_i);
    end
  end

  // walk down so the lowest firing slot wins
  always_comb begin
    hit_o = '0;
    for (int i = int'(NumSlots) - 1; i >= 0; i--) begin
      if (fire[i]) begin
        hit_o.fired = 1'b1;
        hit_o.slot  = SlotIdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/debug_trigger_address_match.sv
// Debug trigger unit: address-match breakpoints with CSR access, top level.
//
// One request channel (req_i) and one response channel (rsp_o), valid/ready.
// Each request transaction is a CSR read, a CSR write or an access check, and
// yields exactly one response transaction. A read returns the selected register;
// a write returns all zeros; a check compares the address, kind and privilege
// against every slot in parallel and reports the lowest firing slot with the
// address as trap value.
// Pipeline: a request passes two register stages, the request register and then
// the response register, before it is presented on rsp_o.
// Throughput: one transaction per cycle unless rsp_o stalls; the path between the
// two registers is the slot compare and priority pick, or the CSR read mux and write.
// CSR writes take effect when the request leaves the request register, so a
// following transaction always sees them.
// Reset clears all slots, tselect and tcontrol and empties both stages.
// When rsp_o stalls, the response register holds, one more request may wait in
// the request register, and req_i.ready then drops until rsp_o drains.
`default_nettype none
`include "debug_trigger_address_match_macros.svh"

module debug_trigger_address_match import dtam_pkg::*; #(
  parameter int unsigned NumSlots = NumSlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtam_req_if.sink  req_i,
  dtam_rsp_if.source rsp_o
);

  // request register
  logic            in_vld_q;
  logic [1:0]      op_q;
  logic [1:0]      rsel_q;
  logic [XLEN-1:0] wdata_q;
  logic [XLEN-1:0] addr_q;
  logic [1:0]      kind_q;
  logic [1:0]      priv_q;

  // response register
  logic                out_vld_q;
  logic [XLEN-1:0]     rdata_q, rdata_d;
  logic                fired_q, fired_d;
  logic [SlotIdxW-1:0] slot_q, slot_d;
  logic [XLEN-1:0]     tval_q, tval_d;

  logic            advance;
  logic            commit;
  wr_t             wr;
  logic [XLEN-1:0] rd_data;
  logic [XLEN-1:0] ctrl [NumSlots];
  logic [XLEN-1:0] cmp  [NumSlots];
  logic            mte;
  hit_t            hit;

  assign advance     = !out_vld_q || rsp_o.ready;
  assign commit      = in_vld_q && advance;
  assign req_i.ready = !in_vld_q || advance;

  assign wr.en   = commit && (op_q == OP_WRITE);
  assign wr.sel  = reg_sel_e'(rsel_q);
  assign wr.data = wdata_q;

  dtam_regs #(.NumSlots(NumSlots)) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_sel_i  (reg_sel_e'(rsel_q)),
    .rd_data_o (rd_data),
    .ctrl_o    (ctrl),
    .cmp_o     (cmp),
    .mte_o     (mte)
  );

  dtam_match #(.NumSlots(NumSlots)) u_match (
    .ctrl_i (ctrl),
    .cmp_i  (cmp),
    .mte_i  (mte),
    .addr_i (addr_q),
    .kind_i (kind_q),
    .priv_i (priv_q),
    .hit_o  (hit)
  );

  always_comb begin
    fired_d = (op_q == OP_CHECK) && hit.fired;
    rdata_d = (op_q == OP_READ) ? rd_data : '0;
    slot_d  = fired_d ? hit.slot : '0;
    tval_d  = fired_d ? addr_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q    <= req_i.opcode;
      rsel_q  <= req_i.reg_select;
      wdata_q <= req_i.write_data;
      addr_q  <= req_i.access_address;
      kind_q  <= req_i.access_kind;
      priv_q  <= req_i.privilege_level;
    end
    if (commit) begin
      rdata_q <= rdata_d;
      fired_q <= fired_d;
      slot_q  <= slot_d;
      tval_q  <= tval_d;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.read_data     = rdata_q;
  assign rsp_o.trigger_fired = fired_q;
  assign rsp_o.fired_slot    = slot_q;
  assign rsp_o.trap_value    = tval_q;

  `DTAM_ASSERT(a_quiet_fields, rsp_o.valid && !rsp_o.trigger_fired |-> rsp_o.fired_slot == '0 && rsp_o.trap_value == '0, "fire fields set without a fire")
  `DTAM_ASSERT(a_fire_fields, rsp_o.valid && rsp_o.trigger_fired |-> rsp_o.read_data == '0 && rsp_o.fired_slot < NumSlots, "bad fire response")
  `DTAM_ASSERT(a_commit_fills, commit |=> out_vld_q, "committed transaction lost")

endmodule

`default_nettype wire
